// ===== src/pls_pkg.sv =====
// ----------------------------------------------------------------------------
// pls_pkg: shared definitions for the positional list store
// Capacity, field widths, operation codes and the control word that the
// top level broadcasts to every storage cell.
// ----------------------------------------------------------------------------
package pls_pkg;

  localparam int CAPACITY = 16;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int DATA_W   = 32;

  typedef enum logic [2:0] {
    MODE_INS_AT    = 3'd0,
    MODE_INS_FRONT = 3'd1,
    MODE_INS_END   = 3'd2,
    MODE_DEL_AT    = 3'd3,
    MODE_DEL_FRONT = 3'd4,
    MODE_DEL_END   = 3'd5,
    MODE_READ_AT   = 3'd6
  } mode_t;

  // Control word broadcast along the chain for one operation
  typedef struct packed {
    logic                     ins;        // insert succeeds this cycle
    logic                     del;        // remove succeeds this cycle
    logic                     rd;         // read at position
    logic [CNT_W-1:0]         pos;        // target index
    logic [CNT_W-1:0]         used;       // count before the operation
    logic [CNT_W-1:0]         used_next;  // count after the operation
    logic signed [DATA_W-1:0] value;      // element to insert
  } cell_ctrl_t;

endpackage

// ===== src/pls_cell.sv =====
// ----------------------------------------------------------------------------
// pls_cell: one storage cell of the list chain
// Holds one element. On insert it takes its left neighbor or the new value,
// on remove it takes its right neighbor, otherwise it holds. It also drives
// masked taps for the read position and the last element.
// ----------------------------------------------------------------------------
module pls_cell (
  input  logic                             clk,
  input  logic                             step,
  input  logic [pls_pkg::CNT_W-1:0]        index,
  input  pls_pkg::cell_ctrl_t              ctrl,
  input  logic signed [pls_pkg::DATA_W-1:0] left_data,
  input  logic signed [pls_pkg::DATA_W-1:0] right_data,
  output logic signed [pls_pkg::DATA_W-1:0] data,
  output logic signed [pls_pkg::DATA_W-1:0] read_tap,
  output logic signed [pls_pkg::DATA_W-1:0] last_tap
);

  logic signed [pls_pkg::DATA_W-1:0] data_next;
  logic [pls_pkg::CNT_W-1:0]         last_idx;

  // Select the new content of this cell
  always_comb begin
    data_next = data;
    if (ctrl.ins) begin
      if (index > ctrl.pos) begin
        data_next = left_data;
      end else if (index == ctrl.pos) begin
        data_next = ctrl.value;
      end
    end else if (ctrl.del) begin
      if ((index >= ctrl.pos) && ((index + 1'b1) < ctrl.used)) begin
        data_next = right_data;
      end
    end
  end

  // Drive taps: read from current content, last from updated content
  assign last_idx = ctrl.used_next - 1'b1;
  assign read_tap = (ctrl.rd && (index == ctrl.pos)) ? data : '0;
  assign last_tap = ((ctrl.used_next != '0) && (index == last_idx)) ? data_next : '0;

  // Advance the cell on each transfer
  always_ff @(posedge clk) begin
    if (step) begin
      data <= data_next;
    end
  end

endmodule

// ===== src/positional_list_store_top.sv =====
// ----------------------------------------------------------------------------
// positional_list_store_top: bounded ordered list of signed 32-bit values
// A chain of cells shifts all elements in parallel for insert and remove.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid, in_stall; mode, position, value) carries one
//   operation per transfer. Output channel (out_valid, out_stall; ok,
//   read_value, count, first_value, last_value) carries one result for each
//   operation, in order.
//   The result appears in the output register in the cycle after the input
//   transfer. Throughput: one operation per cycle while no held result is
//   stalled; every cell computes its next content from its neighbors in the
//   same cycle, and the read and last-element taps are an OR over the cells.
//   A new input is taken while the result register is empty or is being
//   drained in that cycle; while the receiver stalls a held result, in_stall
//   is high and the result holds.
//   Reset (rst, synchronous) empties the list and drops any held result.
//   Cell contents are not cleared; only entries below the count are read.
// ----------------------------------------------------------------------------
module positional_list_store_top (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [2:0]                        mode,
  input  logic [4:0]                        position,
  input  logic signed [31:0]                value,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic                              ok,
  output logic signed [31:0]                read_value,
  output logic [4:0]                        count,
  output logic signed [31:0]                first_value,
  output logic signed [31:0]                last_value
);

  localparam int N = pls_pkg::CAPACITY;

  logic [pls_pkg::CNT_W-1:0]         used;
  logic [pls_pkg::CNT_W-1:0]         target;
  logic                              in_xfer;
  logic                              ins_ok;
  logic                              del_ok;
  logic                              rd_ok;
  logic                              ok_c;
  logic                              is_ins;
  logic                              is_del;
  pls_pkg::cell_ctrl_t               ctrl;
  logic signed [pls_pkg::DATA_W-1:0] cell_data [N];
  logic signed [pls_pkg::DATA_W-1:0] read_taps [N];
  logic signed [pls_pkg::DATA_W-1:0] last_taps [N];
  logic signed [pls_pkg::DATA_W-1:0] read_or;
  logic signed [pls_pkg::DATA_W-1:0] last_or;

  assign in_stall = out_valid && out_stall;
  assign in_xfer  = in_valid && !in_stall;

  // Decode the operation and its target index
  always_comb begin
    target = position;
    is_ins = 1'b0;
    is_del = 1'b0;
    unique case (pls_pkg::mode_t'(mode))
      pls_pkg::MODE_INS_AT:    begin is_ins = 1'b1; target = position; end
      pls_pkg::MODE_INS_FRONT: begin is_ins = 1'b1; target = '0; end
      pls_pkg::MODE_INS_END:   begin is_ins = 1'b1; target = used; end
      pls_pkg::MODE_DEL_AT:    begin is_del = 1'b1; target = position; end
      pls_pkg::MODE_DEL_FRONT: begin is_del = 1'b1; target = '0; end
      pls_pkg::MODE_DEL_END:   begin is_del = 1'b1; target = used - 1'b1; end
      pls_pkg::MODE_READ_AT:   begin target = position; end
      default:                 begin target = position; end
    endcase
  end

  assign ins_ok = is_ins && (used < pls_pkg::CNT_W'(N)) && (target <= used);
  assign del_ok = is_del && (target < used);
  assign rd_ok  = (mode == pls_pkg::MODE_READ_AT) && (position < used);
  assign ok_c   = ins_ok || del_ok || rd_ok;

  // Build the broadcast control word
  always_comb begin
    ctrl.ins       = in_xfer && ins_ok;
    ctrl.del       = in_xfer && del_ok;
    ctrl.rd        = rd_ok;
    ctrl.pos       = target;
    ctrl.used      = used;
    ctrl.value     = value;
    ctrl.used_next = ins_ok ? used + 1'b1 : (del_ok ? used - 1'b1 : used);
  end

  // Chain of cells
  for (genvar i = 0; i < N; i++) begin : g_cell
    pls_cell u_cell (
      .clk        (clk),
      .step       (in_xfer),
      .index      (pls_pkg::CNT_W'(i)),
      .ctrl       (ctrl),
      .left_data  ((i == 0) ? '0 : cell_data[(i == 0) ? 0 : i - 1]),
      .right_data ((i == N - 1) ? '0 : cell_data[(i == N - 1) ? i : i + 1]),
      .data       (cell_data[i]),
      .read_tap   (read_taps[i]),
      .last_tap   (last_taps[i])
    );
  end

  // Combine the masked taps
  always_comb begin
    read_or = '0;
    last_or = '0;
    for (int i = 0; i < N; i++) begin
      read_or = read_or | read_taps[i];
      last_or = last_or | last_taps[i];
    end
  end

  // Count register
  always_ff @(posedge clk) begin
    if (rst) begin
      used <= '0;
    end else if (in_xfer) begin
      used <= ctrl.used_next;
    end
  end

  // Result register: load on input transfer, drop on output transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_xfer) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      ok          <= ok_c;
      read_value  <= read_or;
      count       <= ctrl.used_next;
      last_value  <= last_or;
      if (ins_ok && (target == '0)) begin
        first_value <= value;
      end else if (ctrl.used_next == '0) begin
        first_value <= '0;
      end else if (del_ok && (target == '0)) begin
        first_value <= cell_data[1];
      end else begin
        first_value <= cell_data[0];
      end
    end
  end

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    used <= pls_pkg::CNT_W'(N))
    else $error("list count exceeds capacity");

  a_ins_grows: assert property (@(posedge clk) disable iff (rst)
    (in_xfer && ins_ok) |=> (used == $past(used) + 1'b1))
    else $error("successful insert did not grow the list");

  a_fail_holds: assert property (@(posedge clk) disable iff (rst)
    (in_xfer && !ins_ok && !del_ok) |=> (used == $past(used)))
    else $error("count changed without insert or remove");

  a_read_only: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (read_value != '0)) |-> ok)
    else $error("read value reported on a failed operation");

  a_empty_ends: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (count == '0)) |-> ((first_value == '0) && (last_value == '0)))
    else $error("empty list reports end values");
`endif

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the positional list store
// Drives insert, remove and read operations through the valid/stall input
// channel, tracks the list contents in a scoreboard and compares every
// result transfer field by field against the tracked list.
// ----------------------------------------------------------------------------

typedef struct packed {
  logic                       ok;
  logic [pls_pkg::DATA_W-1:0] rd;
  logic [4:0]                 cnt;
  logic [pls_pkg::DATA_W-1:0] first;
  logic [pls_pkg::DATA_W-1:0] last;
} list_result_t;

class list_scoreboard;
  localparam int MAX_PRINT = 40;

  logic [pls_pkg::DATA_W-1:0] cells [pls_pkg::CAPACITY];
  int unsigned                used;
  list_result_t               awaited[$];
  int                         errors;
  int                         results_seen;

  function new();
    used         = 0;
    errors       = 0;
    results_seen = 0;
  endfunction

  // Shift the tail toward the end and drop the value into the gap
  function bit insert_at(int unsigned pos, logic [pls_pkg::DATA_W-1:0] v);
    if (used >= pls_pkg::CAPACITY || pos > used) return 1'b0;
    for (int unsigned i = used; i > pos; i--) cells[i] = cells[i - 1];
    cells[pos] = v;
    used++;
    return 1'b1;
  endfunction

  // Close the gap by shifting the tail toward the front
  function bit remove_at(int unsigned pos);
    if (pos >= used) return 1'b0;
    for (int unsigned i = pos; i + 1 < used; i++) cells[i] = cells[i + 1];
    used--;
    return 1'b1;
  endfunction

  function int unsigned pending();
    return awaited.size();
  endfunction

  // Apply one accepted operation and queue the result it must produce
  function void note_op(logic [2:0] op, logic [4:0] pos,
                        logic [pls_pkg::DATA_W-1:0] val);
    list_result_t r;
    r = '0;
    case (op)
      pls_pkg::MODE_INS_AT:    r.ok = insert_at(pos, val);
      pls_pkg::MODE_INS_FRONT: r.ok = insert_at(0, val);
      pls_pkg::MODE_INS_END:   r.ok = insert_at(used, val);
      pls_pkg::MODE_DEL_AT:    r.ok = remove_at(pos);
      pls_pkg::MODE_DEL_FRONT: r.ok = remove_at(0);
      pls_pkg::MODE_DEL_END: begin
        if (used > 0) r.ok = remove_at(used - 1);
      end
      pls_pkg::MODE_READ_AT: begin
        if (pos < used) begin
          r.rd = cells[pos];
          r.ok = 1'b1;
        end
      end
      default: ;
    endcase
    r.cnt   = used[4:0];
    r.first = (used > 0) ? cells[0] : '0;
    r.last  = (used > 0) ? cells[used - 1] : '0;
    awaited.push_back(r);
  endfunction

  task report(string what);
    if (errors < MAX_PRINT) $display("[%0t] mismatch: %s", $time, what);
    errors++;
  endtask

  // Compare one result transfer with the oldest queued expectation
  task check_result(logic got_ok, logic [pls_pkg::DATA_W-1:0] got_rd,
                    logic [4:0] got_cnt, logic [pls_pkg::DATA_W-1:0] got_first,
                    logic [pls_pkg::DATA_W-1:0] got_last);
    list_result_t want;
    results_seen++;
    if (awaited.size() == 0) begin
      report($sformatf("result #%0d arrived with nothing pending", results_seen));
      return;
    end
    want = awaited.pop_front();
    if (got_ok !== want.ok)
      report($sformatf("result #%0d ok: got %0b want %0b", results_seen, got_ok, want.ok));
    if (got_rd !== want.rd)
      report($sformatf("result #%0d read_value: got %0d want %0d", results_seen,
                       $signed(got_rd), $signed(want.rd)));
    if (got_cnt !== want.cnt)
      report($sformatf("result #%0d count: got %0d want %0d", results_seen,
                       got_cnt, want.cnt));
    if (got_first !== want.first)
      report($sformatf("result #%0d first_value: got %0d want %0d", results_seen,
                       $signed(got_first), $signed(want.first)));
    if (got_last !== want.last)
      report($sformatf("result #%0d last_value: got %0d want %0d", results_seen,
                       $signed(got_last), $signed(want.last)));
  endtask
endclass

module testbench;
  localparam logic [2:0] MODE_UNUSED  = 3'd7;
  localparam int         RANDOM_OPS   = 900;
  localparam int         DRAIN_CYCLES = 10;
  localparam int         CYCLE_LIMIT  = 200000;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [2:0]         mode = '0;
  logic [4:0]         position = '0;
  logic signed [31:0] value = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic               ok;
  logic signed [31:0] read_value;
  logic [4:0]         count;
  logic signed [31:0] first_value;
  logic signed [31:0] last_value;

  list_scoreboard sb = new();
  int unsigned    tick = 0;
  int             burst_left = 0;

  pls_pkg::mode_t ins_modes [3] = '{pls_pkg::MODE_INS_AT, pls_pkg::MODE_INS_FRONT,
                                    pls_pkg::MODE_INS_END};
  pls_pkg::mode_t del_modes [3] = '{pls_pkg::MODE_DEL_AT, pls_pkg::MODE_DEL_FRONT,
                                    pls_pkg::MODE_DEL_END};
  logic [pls_pkg::DATA_W-1:0] edge_values [4] = '{32'h7fff_ffff, 32'h8000_0000,
                                                  32'h0, 32'hffff_ffff};

  positional_list_store_top dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .mode        (mode),
    .position    (position),
    .value       (value),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .ok          (ok),
    .read_value  (read_value),
    .count       (count),
    .first_value (first_value),
    .last_value  (last_value)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // Count cycles, stall the result channel in phases, stop a hung run
  always @(posedge clk) begin
    tick <= tick + 1;
    case ((tick / 300) % 4)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 99) < 30);
      2: out_stall <= ($urandom_range(0, 99) < 75);
      default: out_stall <= ((tick % 7) >= 4);
    endcase
    if (tick >= CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Track every input transfer
  always @(posedge clk) begin
    if (!rst && in_valid && !in_stall) sb.note_op(mode, position, value);
  end

  // Check every result transfer
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall)
      sb.check_result(ok, read_value, count, first_value, last_value);
  end

  // Present one operation and hold it until the transfer; idle between bursts
  task send_op(input logic [2:0] m, input logic [4:0] p, input logic [31:0] v);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 99) < 30) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    mode     <= m;
    position <= p;
    value    <= v;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    burst_left--;
  endtask

  // Build one random operation; alternate between filling and draining
  task random_op(input int idx);
    logic [2:0]  m;
    logic [4:0]  p;
    logic [31:0] v;
    int          r;
    int          ins_hi;
    r      = $urandom_range(0, 99);
    ins_hi = (((idx / 64) % 2) == 0) ? 63 : 28;
    if (r < 3) m = MODE_UNUSED;
    else if (r < ins_hi) m = ins_modes[$urandom_range(0, 2)];
    else if (r < ins_hi + 17) m = pls_pkg::MODE_READ_AT;
    else m = del_modes[$urandom_range(0, 2)];
    if ($urandom_range(0, 99) < 85) p = 5'($urandom_range(0, sb.used));
    else p = 5'($urandom_range(0, 31));
    if ($urandom_range(0, 99) < 10) v = edge_values[$urandom_range(0, 3)];
    else v = $urandom;
    send_op(m, p, v);
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Empty list: reads and removes fail, unused mode still reports
    send_op(pls_pkg::MODE_READ_AT, 5'd0, 32'h1234_5678);
    send_op(pls_pkg::MODE_DEL_FRONT, 5'd0, 32'h0);
    send_op(pls_pkg::MODE_DEL_END, 5'd0, 32'h0);
    send_op(pls_pkg::MODE_DEL_AT, 5'd0, 32'h0);
    send_op(MODE_UNUSED, 5'd0, 32'h0);
    // Inserts with extreme values, past-count and in-range positions
    send_op(pls_pkg::MODE_INS_END, 5'd0, 32'h7fff_ffff);
    send_op(pls_pkg::MODE_INS_FRONT, 5'd31, 32'h8000_0000);
    send_op(pls_pkg::MODE_INS_AT, 5'd1, 32'h0);
    send_op(pls_pkg::MODE_INS_AT, 5'd5, 32'h5a5a_5a5a);
    send_op(pls_pkg::MODE_INS_AT, 5'd31, 32'ha5a5_a5a5);
    send_op(pls_pkg::MODE_INS_AT, 5'd3, 32'hffff_ffff);
    // Reads inside and outside the list
    send_op(pls_pkg::MODE_READ_AT, 5'd0, 32'h0);
    send_op(pls_pkg::MODE_READ_AT, 5'd3, 32'h0);
    send_op(pls_pkg::MODE_READ_AT, 5'd4, 32'h0);
    send_op(pls_pkg::MODE_READ_AT, 5'd31, 32'h0);
    // Removes down to empty, then insert into the empty list at its count
    send_op(pls_pkg::MODE_DEL_AT, 5'd4, 32'h0);
    send_op(pls_pkg::MODE_DEL_AT, 5'd1, 32'h0);
    send_op(pls_pkg::MODE_DEL_FRONT, 5'd0, 32'h0);
    send_op(pls_pkg::MODE_DEL_END, 5'd0, 32'h0);
    send_op(MODE_UNUSED, 5'd31, 32'hffff_ffff);
    send_op(pls_pkg::MODE_DEL_AT, 5'd0, 32'h0);
    send_op(pls_pkg::MODE_INS_AT, 5'd0, 32'h0000_0001);

    for (int i = 0; i < RANDOM_OPS; i++) begin
      // hold off once until the list has answered everything
      if (i == RANDOM_OPS / 2) begin
        in_valid <= 1'b0;
        do @(posedge clk); while (sb.pending() != 0);
        burst_left = 0;
      end
      random_op(i);
    end

    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end
endmodule
